// ===== rtl/morph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morph_pkg
// Shared types, constants and window reduction helpers for the 3x3
// erode/dilate core.
// ----------------------------------------------------------------------------
package morph_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int NUM_CELLS     = 2;    // stored window columns

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH_MODE   = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic             MODE_ERODE       = 1'b0;
    localparam logic             MODE_DILATE      = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } morph_col_t;

    typedef struct packed {
        logic [PIX_W-1:0] and_v;
        logic [PIX_W-1:0] or_v;
    } morph_red_t;

    function automatic morph_red_t col_reduce(input morph_col_t col);
        morph_red_t r;
        r.and_v = col.top & col.mid & col.bot;
        r.or_v  = col.top | col.mid | col.bot;
        return r;
    endfunction

    function automatic morph_red_t red_merge(input morph_red_t a, input morph_red_t b);
        morph_red_t r;
        r.and_v = a.and_v & b.and_v;
        r.or_v  = a.or_v | b.or_v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/morph_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morph_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module morph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/morph_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morph_cell
// One stored window column. Shifts in its neighbor's column and folds its
// own AND/OR into the reduction passed along the chain.
// ----------------------------------------------------------------------------
module morph_cell
    import morph_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift_en,
    input  wire morph_col_t col_in,
    input  wire morph_red_t red_in,
    output morph_col_t      col_q,
    output morph_red_t      red_out
);

    morph_col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_q   = col_reg;
    assign red_out = red_merge(red_in, col_reduce(col_reg));

endmodule

`default_nettype wire

// ===== rtl/morph_3x3_erode_dilate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morph_3x3_erode_dilate_core
// 3x3 binary erosion/dilation over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and gives one
// result per interior pixel, so a frame of W x H pixels yields (W-2) x (H-2)
// results, the last flagged by m_tlast. A result passes the read stage, which
// registers the read of the two line-store RAMs, and then the output register,
// loaded as the window shifts; a stall at the output holds it in the read stage.
// The sustained rate of one pixel per cycle while the output is not stalled is
// set by the single read port of each line store. No clearing pass is needed
// after reset. A write to frame_width or frame_height restarts the frame.
// ----------------------------------------------------------------------------
module morph_3x3_erode_dilate_core
    import morph_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel_value
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [PIX_W-1:0]     m_tdata,   // [7:0] result_value
    output logic                      m_tlast    // last_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             mode_reg;

    logic [CW-1:0]    col_reg, col_next;
    logic [CFG_W-1:0] row_reg, row_next;

    logic [13:0]      w_eff;
    logic [CW-1:0]    w_last;
    logic [CFG_W-1:0] h_eff;
    logic [CFG_W-1:0] h_last;

    logic             s_accept;
    logic             geom_wr;

    logic             a_valid_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [CW-1:0]    a_addr_reg;
    logic             a_emit_reg;
    logic             a_last_reg;
    logic             a_go;
    logic             out_free;

    logic [PIX_W-1:0] upper_rdata;
    logic [PIX_W-1:0] middle_rdata;

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;

    morph_col_t       new_col;
    morph_col_t       cell_col [NUM_CELLS+1];
    morph_red_t       cell_red [NUM_CELLS+1];
    logic [PIX_W-1:0] result;

    // configuration
    assign geom_wr = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            mode_reg   <= MODE_ERODE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                REG_MORPH_MODE:   mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg < 12'd3) begin
            w_eff = 14'd3;
        end else begin
            w_eff = {2'b00, width_reg};
        end
        if (w_eff > 14'(MAX_WIDTH)) begin
            w_eff = 14'(MAX_WIDTH);
        end
        w_last = CW'(w_eff - 14'd1);
        h_eff  = (height_reg < 12'd3) ? 12'd3 : height_reg;
        h_last = h_eff - 12'd1;
    end

    // position counters
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (s_accept) begin
            if (col_reg == w_last) begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + 12'd1;
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // read stage
    assign out_free = !m_valid_reg || m_tready;
    assign a_go     = a_valid_reg && (!a_emit_reg || out_free);
    assign s_tready = !a_valid_reg || a_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_go) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_pix_reg  <= s_tdata;
            a_addr_reg <= col_reg;
            a_emit_reg <= (row_reg >= 12'd2) && (col_reg >= CW'(2));
            a_last_reg <= (row_reg == h_last) && (col_reg == w_last);
        end
    end

    morph_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_upper (
        .aclk   (aclk),
        .wr_en  (a_go),
        .wr_addr(a_addr_reg),
        .wr_data(middle_rdata),
        .rd_en  (s_accept),
        .rd_addr(col_reg),
        .rd_data(upper_rdata)
    );

    morph_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_middle (
        .aclk   (aclk),
        .wr_en  (a_go),
        .wr_addr(a_addr_reg),
        .wr_data(a_pix_reg),
        .rd_en  (s_accept),
        .rd_addr(col_reg),
        .rd_data(middle_rdata)
    );

    // window chain, newest column enters at the top index
    assign new_col.top = upper_rdata;
    assign new_col.mid = middle_rdata;
    assign new_col.bot = a_pix_reg;

    assign cell_col[NUM_CELLS] = new_col;
    assign cell_red[NUM_CELLS] = col_reduce(new_col);

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        morph_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift_en(a_go),
            .col_in  (cell_col[k+1]),
            .red_in  (cell_red[k+1]),
            .col_q   (cell_col[k]),
            .red_out (cell_red[k])
        );
    end

    assign result = (mode_reg == MODE_DILATE) ? cell_red[0].or_v : cell_red[0].and_v;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_go && a_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go && a_emit_reg) begin
            m_data_reg <= result;
            m_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
